// ===== rtl/core/pic_pkg.sv =====
package pic_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_RAISE = 3'd2,
    CMD_LOWER = 3'd3,
    CMD_EDGE  = 3'd4,
    CMD_ACK   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OCW2_EOI_NONSPEC = 3'd1,
    OCW2_EOI_SPEC    = 3'd3,
    OCW2_SET_PRIO    = 3'd6
  } ocw2_t;

  typedef enum logic [2:0] {
    PH_ICW1   = 3'd0,
    PH_ICW2   = 3'd1,
    PH_ICW3   = 3'd2,
    PH_ICW4   = 3'd3,
    PH_NORMAL = 3'd4
  } phase_t;

  localparam logic [7:0] MASK_RESET   = 8'hFF;
  localparam logic [2:0] LOWEST_RESET = 3'd7;
  localparam logic [2:0] SPURIOUS_LVL = 3'd7;

  // command port bit positions
  localparam int unsigned ICW1_BIT    = 4;
  localparam int unsigned OCW3_BIT    = 3;
  localparam int unsigned OCW3_RR_BIT = 1;
  localparam int unsigned OCW3_RS_BIT = 0;

  typedef struct packed {
    logic [2:0] cmd;
    logic       port_offset;
    logic [7:0] write_data;
    logic [2:0] irq_line;
  } item_t;

  typedef struct packed {
    logic [7:0] result_data;
    logic       int_request;
  } result_t;

  // {found, level} of the highest-ranked set bit; rank 0 sits just above lowest
  function automatic logic [3:0] best_level(input logic [7:0] bits,
                                            input logic [2:0] lowest);
    logic [3:0] res;
    logic [2:0] lvl;
    res = 4'd0;
    for (int r = 7; r >= 0; r--) begin
      lvl = lowest + 3'd1 + 3'(r);
      if (bits[lvl]) begin
        res = {1'b1, lvl};
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] rank_of(input logic [2:0] level,
                                         input logic [2:0] lowest);
    return level - lowest - 3'd1;
  endfunction

  function automatic logic irq_active(input logic [7:0] req,
                                      input logic [7:0] mask,
                                      input logic [7:0] srv,
                                      input logic [2:0] lowest);
    logic [3:0] p;
    logic [3:0] s;
    logic       act;
    p = best_level(req & ~mask & ~srv, lowest);
    s = best_level(srv, lowest);
    if (!p[3]) begin
      act = 1'b0;
    end else if (!s[3]) begin
      act = 1'b1;
    end else begin
      act = rank_of(p[2:0], lowest) < rank_of(s[2:0], lowest);
    end
    return act;
  endfunction

endpackage

// ===== rtl/core/pic_in_stage.sv =====
module pic_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [2:0]     in_cmd,
  input  logic           in_port_offset,
  input  logic [7:0]     in_write_data,
  input  logic [2:0]     in_irq_line,
  input  logic           adv,
  output logic           s1_valid,
  output pic_pkg::item_t s1_item
);

  logic           valid_r;
  logic           valid_nxt;
  pic_pkg::item_t item_r;
  logic           load;

  assign in_stall = valid_r && !adv;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= '{cmd: in_cmd, port_offset: in_port_offset,
                  write_data: in_write_data, irq_line: in_irq_line};
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

// ===== rtl/core/pic_core.sv =====
module pic_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  pic_pkg::item_t   item,
  output pic_pkg::result_t res
);

  logic [7:0] req_r, req_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] srv_r, srv_nxt;
  logic [7:0] edge_r, edge_nxt;
  logic [1:0] icw1_r, icw1_nxt;     // single and ICW4-needed bits
  logic [4:0] base_r, base_nxt;     // vector base bits 7:3
  logic       icw4_r, icw4_nxt;     // 8086 mode
  logic [2:0] phase_r, phase_nxt;
  logic       rsel_r, rsel_nxt;
  logic [2:0] low_r, low_nxt;

  logic [7:0] line_bit;
  logic [7:0] wd;
  logic [3:0] srv_best;
  logic [3:0] pend_best;
  logic       ack_act;
  logic       eoi;
  logic [2:0] eoi_lvl;
  logic [7:0] eoi_bit;
  logic [7:0] rdata;

  assign line_bit  = 8'd1 << item.irq_line;
  assign wd        = item.write_data;
  assign srv_best  = pic_pkg::best_level(srv_r, low_r);
  assign pend_best = pic_pkg::best_level(req_r & ~mask_r & ~srv_r, low_r);
  assign ack_act   = pic_pkg::irq_active(req_r, mask_r, srv_r, low_r);
  assign eoi_bit   = 8'd1 << eoi_lvl;

  always_comb begin
    req_nxt   = req_r;
    mask_nxt  = mask_r;
    srv_nxt   = srv_r;
    edge_nxt  = edge_r;
    icw1_nxt  = icw1_r;
    base_nxt  = base_r;
    icw4_nxt  = icw4_r;
    phase_nxt = phase_r;
    rsel_nxt  = rsel_r;
    low_nxt   = low_r;
    rdata     = 8'd0;
    eoi       = 1'b0;
    eoi_lvl   = wd[2:0];
    case (item.cmd)
      pic_pkg::CMD_WRITE: begin
        if (item.port_offset) begin
          case (phase_r)
            pic_pkg::PH_ICW1: begin
            end
            pic_pkg::PH_ICW2: begin
              base_nxt = wd[7:3];
              if (icw1_r[1]) begin
                phase_nxt = icw1_r[0] ? pic_pkg::PH_ICW4 : pic_pkg::PH_NORMAL;
              end else begin
                phase_nxt = pic_pkg::PH_ICW3;
              end
            end
            pic_pkg::PH_ICW3: begin
              phase_nxt = icw1_r[0] ? pic_pkg::PH_ICW4 : pic_pkg::PH_NORMAL;
            end
            pic_pkg::PH_ICW4: begin
              icw4_nxt  = wd[0];
              phase_nxt = pic_pkg::PH_NORMAL;
            end
            default: begin
              mask_nxt = wd;
            end
          endcase
        end else if (wd[pic_pkg::ICW1_BIT]) begin
          icw1_nxt  = wd[1:0];
          phase_nxt = pic_pkg::PH_ICW2;
        end else if (wd[pic_pkg::OCW3_BIT]) begin
          if (wd[pic_pkg::OCW3_RR_BIT]) begin
            rsel_nxt = wd[pic_pkg::OCW3_RS_BIT];
          end
        end else begin
          case (wd[7:5])
            pic_pkg::OCW2_EOI_NONSPEC: begin
              eoi     = srv_best[3];
              eoi_lvl = srv_best[2:0];
            end
            pic_pkg::OCW2_EOI_SPEC: begin
              eoi = 1'b1;
            end
            pic_pkg::OCW2_SET_PRIO: begin
              low_nxt = wd[2:0];
            end
            default: begin
            end
          endcase
        end
      end
      pic_pkg::CMD_READ: begin
        if (item.port_offset) begin
          rdata = mask_r;
        end else begin
          rdata = rsel_r ? srv_r : req_r;
        end
      end
      pic_pkg::CMD_RAISE: begin
        req_nxt = req_r | line_bit;
      end
      pic_pkg::CMD_LOWER: begin
        req_nxt = req_r & ~line_bit;
      end
      pic_pkg::CMD_EDGE: begin
        req_nxt  = req_r | line_bit;
        edge_nxt = edge_r | line_bit;
      end
      pic_pkg::CMD_ACK: begin
        rdata = {base_r, pic_pkg::SPURIOUS_LVL};
        if (ack_act) begin
          srv_nxt = srv_r | (8'd1 << pend_best[2:0]);
          if (icw4_r) begin
            rdata = {base_r, pend_best[2:0]};
          end
        end
      end
      default: begin
      end
    endcase
    if (eoi) begin
      srv_nxt = srv_r & ~eoi_bit;
      if ((edge_r & eoi_bit) != 8'd0) begin
        req_nxt  = req_r & ~eoi_bit;
        edge_nxt = edge_r & ~eoi_bit;
      end
    end
  end

  assign res.result_data = rdata;
  assign res.int_request = pic_pkg::irq_active(req_nxt, mask_nxt, srv_nxt, low_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r   <= 8'd0;
      mask_r  <= pic_pkg::MASK_RESET;
      srv_r   <= 8'd0;
      edge_r  <= 8'd0;
      icw1_r  <= 2'd0;
      base_r  <= 5'd0;
      icw4_r  <= 1'b0;
      phase_r <= pic_pkg::PH_ICW1;
      rsel_r  <= 1'b0;
      low_r   <= pic_pkg::LOWEST_RESET;
    end else if (fire) begin
      req_r   <= req_nxt;
      mask_r  <= mask_nxt;
      srv_r   <= srv_nxt;
      edge_r  <= edge_nxt;
      icw1_r  <= icw1_nxt;
      base_r  <= base_nxt;
      icw4_r  <= icw4_nxt;
      phase_r <= phase_nxt;
      rsel_r  <= rsel_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

// ===== rtl/core/pic_out_stage.sv =====
module pic_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pic_pkg::result_t res,
  output logic             adv,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_result_data,
  output logic             out_int_request
);

  logic             valid_r;
  logic             valid_nxt;
  pic_pkg::result_t res_r;

  assign adv = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid       = valid_r;
  assign out_result_data = res_r.result_data;
  assign out_int_request = res_r.int_request;

endmodule

// ===== rtl/core/interrupt_controller_8259.sv =====
// 8-input programmable interrupt controller, no cascading.
// Input channel (in_valid/in_stall): one transaction is a port write, port
// read, line raise/lower/edge event or an interrupt acknowledge, selected
// by in_cmd. Port offset 0 is command/status, 1 is data/mask.
// Output channel (out_valid/out_stall): exactly one transaction per input
// transaction, in order: read byte or acknowledge vector (zero otherwise)
// and the interrupt request level after the command took effect.
// Path: the input register, then rotating-priority logic into the result
// register, which drives out_valid. Throughput: one transaction per cycle
// while out_stall is low; the priority encode over 8 levels sets the path.
// out_stall holds the result register; the input register still takes one
// more transaction and then in_stall rises until the result drains.
// Reset (rst_n low, synchronous): mask all ones, lowest priority level 7,
// init sequence waits for ICW1, all other state and both stages cleared.
module interrupt_controller_8259 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_cmd,
  input  logic       in_port_offset,
  input  logic [7:0] in_write_data,
  input  logic [2:0] in_irq_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_result_data,
  output logic       out_int_request
);

  logic             adv;
  logic             s1_valid;
  logic             fire;
  pic_pkg::item_t   s1_item;
  pic_pkg::result_t core_res;

  assign fire = s1_valid && adv;

  pic_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_port_offset (in_port_offset),
    .in_write_data  (in_write_data),
    .in_irq_line    (in_irq_line),
    .adv            (adv),
    .s1_valid       (s1_valid),
    .s1_item        (s1_item)
  );

  pic_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item),
    .res   (core_res)
  );

  pic_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (fire),
    .res             (core_res),
    .adv             (adv),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_result_data (out_result_data),
    .out_int_request (out_int_request)
  );

`ifndef SYNTHESIS
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid |-> !in_stall)
    else $error("in_stall with empty input stage");

  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid)
    else $error("result lost after advance");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !s1_valid) |=> !out_valid)
    else $error("result repeated after drain");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int RANDOM_ITEMS = 1200;
  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] in_cmd = '0;
  logic       in_port_offset = 1'b0;
  logic [7:0] in_write_data = '0;
  logic [2:0] in_irq_line = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_result_data;
  logic       out_int_request;

  interrupt_controller_8259 u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_port_offset (in_port_offset),
    .in_write_data  (in_write_data),
    .in_irq_line    (in_irq_line),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_data(out_result_data),
    .out_int_request(out_int_request)
  );

  always #5 clk = ~clk;

  // shadow controller state
  logic [7:0] irr_q = '0;
  logic [7:0] imr_q = pic_pkg::MASK_RESET;
  logic [7:0] isr_q = '0;
  logic [7:0] edge_q = '0;
  logic [7:0] icw1_q = '0;
  logic [7:0] vec_base_q = '0;
  logic [7:0] icw4_q = '0;
  pic_pkg::phase_t init_ph = pic_pkg::PH_ICW1;
  logic       rd_isr_q = 1'b0;
  logic [2:0] lowest_q = pic_pkg::LOWEST_RESET;

  pic_pkg::item_t   pic_ops_q[$];
  pic_pkg::result_t pic_replies_q[$];
  pic_pkg::item_t   cur_op;
  pic_pkg::result_t want;
  int      total_ops;
  int      phase_len;
  int      sent_cnt = 0;
  int      err_cnt = 0;
  int      quiet_cycles = 0;
  logic [1:0] idle_mode = 2'd0;

  // {found, level} of highest-ranked set bit under current rotation
  function automatic logic [3:0] top_level(input logic [7:0] bits);
    logic [3:0] found;
    logic [2:0] lvl;
    found = '0;
    for (int r = 0; r < 8; r++) begin
      lvl = lowest_q + 3'd1 + 3'(r);
      if (!found[3] && bits[lvl]) found = {1'b1, lvl};
    end
    return found;
  endfunction

  function automatic logic [2:0] prio_rank(input logic [2:0] lvl);
    return lvl + 3'd7 - lowest_q;
  endfunction

  function automatic logic irq_up();
    logic [3:0] p;
    logic [3:0] s;
    p = top_level(irr_q & ~imr_q & ~isr_q);
    s = top_level(isr_q);
    if (!p[3]) return 1'b0;
    if (!s[3]) return 1'b1;
    return prio_rank(p[2:0]) < prio_rank(s[2:0]);
  endfunction

  task automatic retire_level(input logic [2:0] lvl);
    isr_q[lvl] = 1'b0;
    if (edge_q[lvl]) begin
      irr_q[lvl] = 1'b0;
      edge_q[lvl] = 1'b0;
    end
  endtask

  task automatic port_write(input logic off, input logic [7:0] d);
    logic [3:0] lv;
    if (off) begin
      case (init_ph)
        pic_pkg::PH_ICW1: ;
        pic_pkg::PH_ICW2: begin
          vec_base_q = d;
          if (icw1_q[1]) init_ph = icw1_q[0] ? pic_pkg::PH_ICW4 : pic_pkg::PH_NORMAL;
          else init_ph = pic_pkg::PH_ICW3;
        end
        pic_pkg::PH_ICW3: init_ph = icw1_q[0] ? pic_pkg::PH_ICW4 : pic_pkg::PH_NORMAL;
        pic_pkg::PH_ICW4: begin
          icw4_q = d;
          init_ph = pic_pkg::PH_NORMAL;
        end
        default: imr_q = d;
      endcase
    end else if (d[pic_pkg::ICW1_BIT]) begin
      icw1_q = d;
      init_ph = pic_pkg::PH_ICW2;
    end else if (d[pic_pkg::OCW3_BIT]) begin
      if (d[pic_pkg::OCW3_RR_BIT]) rd_isr_q = d[pic_pkg::OCW3_RS_BIT];
    end else begin
      case (d[7:5])
        pic_pkg::OCW2_EOI_NONSPEC: begin
          lv = top_level(isr_q);
          if (lv[3]) retire_level(lv[2:0]);
        end
        pic_pkg::OCW2_EOI_SPEC: retire_level(d[2:0]);
        pic_pkg::OCW2_SET_PRIO: lowest_q = d[2:0];
        default: ;
      endcase
    end
  endtask

  task automatic predict_reply(input pic_pkg::item_t op);
    pic_pkg::result_t r;
    logic [3:0] lv;
    logic [7:0] sel;
    r = '0;
    sel = 8'd1 << op.irq_line;
    case (op.cmd)
      pic_pkg::CMD_WRITE: port_write(op.port_offset, op.write_data);
      pic_pkg::CMD_READ:  r.result_data = op.port_offset ? imr_q : (rd_isr_q ? isr_q : irr_q);
      pic_pkg::CMD_RAISE: irr_q = irr_q | sel;
      pic_pkg::CMD_LOWER: irr_q = irr_q & ~sel;
      pic_pkg::CMD_EDGE: begin
        irr_q = irr_q | sel;
        edge_q = edge_q | sel;
      end
      pic_pkg::CMD_ACK: begin
        r.result_data = {vec_base_q[7:3], pic_pkg::SPURIOUS_LVL};
        if (irq_up()) begin
          lv = top_level(irr_q & ~imr_q & ~isr_q);
          isr_q[lv[2:0]] = 1'b1;
          if (icw4_q[0]) r.result_data[2:0] = lv[2:0];
        end
      end
      default: ;
    endcase
    r.int_request = irq_up();
    pic_replies_q.push_back(r);
  endtask

  function automatic void add_op(input logic [2:0] c, input logic off,
                                 input logic [7:0] d, input logic [2:0] line);
    pic_pkg::item_t it;
    it.cmd = c;
    it.port_offset = off;
    it.write_data = d;
    it.irq_line = line;
    pic_ops_q.push_back(it);
  endfunction

  task automatic build_random_ops();
    int k;
    int sel;
    logic [7:0] w;
    logic [2:0] c;
    k = 0;
    while (k < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      c = ($urandom_range(0, 1) != 0) ? pic_pkg::CMD_EDGE : pic_pkg::CMD_RAISE;
      if (sel < 6) begin
        // full init sequence, then a mask
        w = {3'($urandom), 1'b1, 4'($urandom)};
        add_op(pic_pkg::CMD_WRITE, 1'b0, w, 3'($urandom));
        add_op(pic_pkg::CMD_WRITE, 1'b1, 8'($urandom), 3'($urandom));
        k = k + 2;
        if (!w[1]) begin
          add_op(pic_pkg::CMD_WRITE, 1'b1, 8'($urandom), 3'($urandom));
          k = k + 1;
        end
        if (w[0]) begin
          w = 8'($urandom);
          w[0] = ($urandom_range(0, 3) != 0);
          add_op(pic_pkg::CMD_WRITE, 1'b1, w, 3'($urandom));
          k = k + 1;
        end
        w = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        add_op(pic_pkg::CMD_WRITE, 1'b1, w, 3'($urandom));
        k = k + 1;
      end else begin
        if (sel < 30) add_op(c, 1'($urandom), 8'($urandom), 3'($urandom));
        else if (sel < 38)
          add_op(pic_pkg::CMD_LOWER, 1'($urandom), 8'($urandom), 3'($urandom));
        else if (sel < 54)
          add_op(pic_pkg::CMD_ACK, 1'($urandom), 8'($urandom), 3'($urandom));
        else if (sel < 62)
          add_op(pic_pkg::CMD_WRITE, 1'b0,
                 {pic_pkg::OCW2_EOI_NONSPEC, 2'b00, 3'($urandom)}, 3'($urandom));
        else if (sel < 68)
          add_op(pic_pkg::CMD_WRITE, 1'b0,
                 {pic_pkg::OCW2_EOI_SPEC, 2'b00, 3'($urandom)}, 3'($urandom));
        else if (sel < 72)
          add_op(pic_pkg::CMD_WRITE, 1'b0,
                 {pic_pkg::OCW2_SET_PRIO, 2'b00, 3'($urandom)}, 3'($urandom));
        else if (sel < 75)
          add_op(pic_pkg::CMD_WRITE, 1'b0, {3'($urandom), 2'b00, 3'($urandom)},
                 3'($urandom));
        else if (sel < 80)
          add_op(pic_pkg::CMD_WRITE, 1'b0, {3'($urandom), 2'b01, 3'($urandom)},
                 3'($urandom));
        else if (sel < 90)
          add_op(pic_pkg::CMD_READ, 1'($urandom), 8'($urandom), 3'($urandom));
        else if (sel < 95)
          add_op(pic_pkg::CMD_WRITE, 1'b1, 8'($urandom), 3'($urandom));
        else if (sel < 98)
          add_op(pic_pkg::CMD_WRITE, 1'($urandom), 8'($urandom), 3'($urandom));
        else add_op(($urandom_range(0, 1) != 0) ? CMD_RSVD7 : CMD_RSVD6,
                    1'($urandom), 8'($urandom), 3'($urandom));
        k = k + 1;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur_op.cmd = in_cmd;
        cur_op.port_offset = in_port_offset;
        cur_op.write_data = in_write_data;
        cur_op.irq_line = in_irq_line;
        predict_reply(cur_op);
        sent_cnt = sent_cnt + 1;
      end
      idle_mode <= (sent_cnt >= 2 * phase_len) ? 2'd2 : (sent_cnt >= phase_len) ? 2'd1 : 2'd0;
      if (!in_valid || !in_stall) begin
        if (pic_ops_q.size() != 0
            && $urandom_range(0, 99) >= ((idle_mode == 2'd0) ? 38 :
                                         (idle_mode == 2'd1) ? 48 : 0)
            && !((sent_cnt == phase_len || sent_cnt == 2 * phase_len)
                 && pic_replies_q.size() != 0)) begin
          cur_op = pic_ops_q.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_op.cmd;
          in_port_offset <= cur_op.port_offset;
          in_write_data <= cur_op.write_data;
          in_irq_line <= cur_op.irq_line;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pic_replies_q.size() == 0) begin
          $error("unexpected transaction: result_data=%02h int_request=%0b",
                 out_result_data, out_int_request);
          err_cnt = err_cnt + 1;
        end else begin
          want = pic_replies_q.pop_front();
          if (out_result_data !== want.result_data) begin
            $error("result_data: expected %02h, got %02h", want.result_data, out_result_data);
            err_cnt = err_cnt + 1;
          end
          if (out_int_request !== want.int_request) begin
            $error("int_request: expected %0b, got %0b", want.int_request, out_int_request);
            err_cnt = err_cnt + 1;
          end
        end
      end
      out_stall <= $urandom_range(0, 99) < ((idle_mode == 2'd0) ? 48 :
                                            (idle_mode == 2'd1) ? 38 : 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // directed: reset reads, ignored writes, init, nesting, EOIs, rotation
    add_op(pic_pkg::CMD_READ, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_READ, 1'b1, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b1, 8'h5A, 3'd0);
    add_op(CMD_RSVD6, 1'b1, 8'hFF, 3'd7);
    add_op(CMD_RSVD7, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_ACK, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_RAISE, 1'b0, 8'h00, 3'd3);
    add_op(pic_pkg::CMD_WRITE, 1'b0, 8'h11, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b1, 8'hFF, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b1, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b1, 8'h01, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b1, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_EDGE, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_ACK, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_EDGE, 1'b0, 8'h00, 3'd7);
    add_op(pic_pkg::CMD_ACK, 1'b1, 8'hFF, 3'd7);
    add_op(pic_pkg::CMD_WRITE, 1'b0, 8'h0B, 3'd0);
    add_op(pic_pkg::CMD_READ, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b0, {pic_pkg::OCW2_EOI_NONSPEC, 5'd0}, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b0, {pic_pkg::OCW2_SET_PRIO, 5'd3}, 3'd0);
    add_op(pic_pkg::CMD_ACK, 1'b0, 8'h00, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b0, {pic_pkg::OCW2_EOI_SPEC, 5'd7}, 3'd0);
    add_op(pic_pkg::CMD_LOWER, 1'b0, 8'h00, 3'd3);
    add_op(pic_pkg::CMD_WRITE, 1'b0, {pic_pkg::OCW2_EOI_NONSPEC, 5'd0}, 3'd0);
    add_op(pic_pkg::CMD_WRITE, 1'b0, 8'h08, 3'd0);
    add_op(pic_pkg::CMD_READ, 1'b0, 8'h00, 3'd0);
    build_random_ops();
    total_ops = pic_ops_q.size();
    phase_len = total_ops / 3;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (pic_ops_q.size() != 0 || in_valid || pic_replies_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pic_replies_q.size() != 0) begin
      $error("%0d expected transactions never arrived", pic_replies_q.size());
      err_cnt = err_cnt + 1;
    end
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
